/* rtl/ucfs_pkg.sv */
// Shared types and constants for the UART line and COBS frame splitter.
package ucfs_pkg;

    // Sizing of the line and frame stores
    localparam int LINE_STORE_BYTES  = 128;
    localparam int FRAME_STORE_BYTES = 32;

    localparam int TEXT_CNT_W  = $clog2(LINE_STORE_BYTES);
    localparam int FRAME_CNT_W = $clog2(FRAME_STORE_BYTES + 1);
    localparam int LEN_CMP_W   = (TEXT_CNT_W > 7) ? TEXT_CNT_W : 7;

    // Byte codes and frame format
    localparam logic [7:0] COBS_NO_ZERO_CODE    = 8'hFF;
    localparam logic [7:0] REQ_TYPE_START       = 8'h01;
    localparam logic [7:0] REQ_PROTOCOL_VERSION = 8'h01;
    localparam logic [2:0] REQ_DECODED_LEN      = 3'd6;
    localparam logic [2:0] DEC_COUNT_MAX        = 3'd7;
    localparam logic [7:0] CHAR_CR              = 8'h0D;
    localparam logic [7:0] CHAR_LF              = 8'h0A;
    localparam logic [6:0] LINE_LEN_MAX         = 7'd127;

    typedef enum logic [1:0] {
        EV_TEXT     = 2'd0,
        EV_LINE_END = 2'd1,
        EV_TOO_LONG = 2'd2,
        EV_CAPTURE  = 2'd3
    } event_kind_t;

    // One result item
    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [7:0]  ch;
        logic [6:0]  len;
        logic [31:0] count;
    } res_t;

    // Control from the splitter to the COBS decoder
    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] data;
    } dec_ctrl_t;

    // Status from the COBS decoder
    typedef struct packed {
        logic        block_done;
        logic        size_ok;
        logic        header_ok;
        logic [31:0] count;
    } dec_stat_t;

endpackage

/* rtl/ucfs_cobs_dec.sv */
// Streaming COBS decoder holding the first six decoded bytes of a frame.
module ucfs_cobs_dec
    import ucfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dec_ctrl_t ctrl,
    output dec_stat_t stat
);

    logic [7:0] block_left_reg, block_left_next;
    logic       zero_pending_reg, zero_pending_next;
    logic [2:0] dcount_reg, dcount_next;
    logic [7:0] bytes_reg [6];
    logic       append_en;
    logic [7:0] append_val;

    // Decode one frame byte: code byte or block data
    always_comb
    begin
        block_left_next   = block_left_reg;
        zero_pending_next = zero_pending_reg;
        dcount_next       = dcount_reg;
        append_en         = 1'b0;
        append_val        = ctrl.data;
        if (ctrl.clear)
        begin
            block_left_next   = 8'd0;
            zero_pending_next = 1'b0;
            dcount_next       = 3'd0;
        end
        else if (ctrl.step)
        begin
            if (block_left_reg == 8'd0)
            begin
                append_en         = zero_pending_reg;
                append_val        = 8'd0;
                zero_pending_next = (ctrl.data != COBS_NO_ZERO_CODE);
                block_left_next   = (ctrl.data == 8'd0) ? 8'd0 : ctrl.data - 8'd1;
            end
            else
            begin
                append_en       = 1'b1;
                block_left_next = block_left_reg - 8'd1;
            end
            if (append_en && dcount_reg != DEC_COUNT_MAX)
            begin
                dcount_next = dcount_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_left_reg   <= 8'd0;
            zero_pending_reg <= 1'b0;
            dcount_reg       <= 3'd0;
        end
        else
        begin
            block_left_reg   <= block_left_next;
            zero_pending_reg <= zero_pending_next;
            dcount_reg       <= dcount_next;
        end
    end

    // Store decoded bytes at the current count
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            if (!ctrl.clear && append_en && dcount_reg == 3'(i))
            begin
                bytes_reg[i] <= append_val;
            end
        end
    end

    assign stat.block_done = (block_left_reg == 8'd0);
    assign stat.size_ok    = (dcount_reg == REQ_DECODED_LEN);
    assign stat.header_ok  = (bytes_reg[0] == REQ_TYPE_START) &&
                             (bytes_reg[1] == REQ_PROTOCOL_VERSION);
    assign stat.count      = {bytes_reg[5], bytes_reg[4], bytes_reg[3], bytes_reg[2]};

`ifndef ASSERT_OFF
    a_code_one_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && !ctrl.clear && block_left_reg == 8'd0 && ctrl.data == 8'd1
        |=> block_left_reg == 8'd0 && zero_pending_reg)
        else $error("code byte one left block data pending");
`endif

endmodule

/* rtl/ucfs_splitter.sv */
// Byte sorter: text line tracking, frame framing and event forming.
module ucfs_splitter
    import ucfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       item_step,
    input  logic [7:0] item_byte,
    output res_t       res
);

    logic                   cfg_mode_reg;
    logic                   binary_reg, binary_next;
    logic [FRAME_CNT_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [TEXT_CNT_W-1:0]  text_cnt_reg, text_cnt_next;
    logic [LEN_CMP_W-1:0]   text_ext;
    logic [6:0]             len_sat;
    dec_ctrl_t              dec_ctrl;
    dec_stat_t              dec_stat;

    ucfs_cobs_dec u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dec_ctrl),
        .stat  (dec_stat)
    );

    // Saturate the line length to the field range
    assign text_ext = LEN_CMP_W'(text_cnt_reg);
    assign len_sat  = (text_ext > LEN_CMP_W'(LINE_LEN_MAX)) ? LINE_LEN_MAX : 7'(text_ext);

    // Sort the item and form its event
    always_comb
    begin
        binary_next    = binary_reg;
        frame_cnt_next = frame_cnt_reg;
        text_cnt_next  = text_cnt_reg;
        res            = '0;
        dec_ctrl.step  = 1'b0;
        dec_ctrl.clear = 1'b0;
        dec_ctrl.data  = item_byte;
        if (item_step)
        begin
            if (binary_reg)
            begin
                if (item_byte == 8'd0)
                begin
                    binary_next    = 1'b0;
                    frame_cnt_next = '0;
                    text_cnt_next  = '0;
                    dec_ctrl.clear = 1'b1;
                    if (frame_cnt_reg != '0 && dec_stat.block_done &&
                        dec_stat.size_ok && dec_stat.header_ok)
                    begin
                        res.valid = 1'b1;
                        res.kind  = EV_CAPTURE;
                        res.count = dec_stat.count;
                    end
                end
                else if (frame_cnt_reg < FRAME_CNT_W'(FRAME_STORE_BYTES))
                begin
                    frame_cnt_next = frame_cnt_reg + FRAME_CNT_W'(1);
                    dec_ctrl.step  = 1'b1;
                end
                else
                begin
                    // Abandon an overlong frame and drop this byte
                    binary_next    = 1'b0;
                    frame_cnt_next = '0;
                    dec_ctrl.clear = 1'b1;
                end
            end
            else if (item_byte == 8'd0)
            begin
                binary_next    = 1'b1;
                frame_cnt_next = '0;
                text_cnt_next  = '0;
                dec_ctrl.clear = 1'b1;
            end
            else if (item_byte == CHAR_CR || item_byte == CHAR_LF)
            begin
                if (text_cnt_reg != '0)
                begin
                    text_cnt_next = '0;
                    res.valid     = 1'b1;
                    res.kind      = EV_LINE_END;
                    res.len       = len_sat;
                end
            end
            else if (text_cnt_reg < TEXT_CNT_W'(LINE_STORE_BYTES - 1))
            begin
                text_cnt_next = text_cnt_reg + TEXT_CNT_W'(1);
                res.valid     = 1'b1;
                res.kind      = EV_TEXT;
                res.ch        = item_byte;
            end
            else
            begin
                // Clear the overlong line and drop the character
                text_cnt_next = '0;
                if (cfg_mode_reg)
                begin
                    res.valid = 1'b1;
                    res.kind  = EV_TOO_LONG;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode_reg  <= 1'b0;
            binary_reg    <= 1'b0;
            frame_cnt_reg <= '0;
            text_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_mode_reg <= cfg_data;
            end
            binary_reg    <= binary_next;
            frame_cnt_reg <= frame_cnt_next;
            text_cnt_reg  <= text_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_open_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        item_step && !binary_reg && item_byte == 8'd0
        |=> binary_reg && text_cnt_reg == '0 && frame_cnt_reg == '0)
        else $error("frame open did not clear line state");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_cnt_reg <= FRAME_CNT_W'(FRAME_STORE_BYTES))
        else $error("frame byte count beyond store size");

    a_text_idle_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        binary_reg |-> text_cnt_reg == '0)
        else $error("line characters pending inside a frame");
`endif

endmodule

/* rtl/uart_line_and_cobs_frame_splitter_unit.sv */
// Top level: input register, splitter and result register.
//
//   channel   handshake                payload
//   -------   ----------------------   ------------------------------------------
//   input     in_valid / in_ready      rx_byte
//   result    out_valid / out_ready    event_kind, text_char, line_length,
//                                      capture_frame_count
//   config    cfg_we                   config_mode_active
//
// An accepted item is held in the input register and passes the splitter; its result is
// then loaded into the result register. One item is accepted per cycle while results are
// taken; the splitter's state update for each item sets that rate. A stalled result holds
// the input register; items with no result still wait for the result register to free.
// Reset clears all control state at once.
module uart_line_and_cobs_frame_splitter_unit
    import ucfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        config_mode_active,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [7:0]  text_char,
    output logic [6:0]  line_length,
    output logic [31:0] capture_frame_count
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;
    res_t       res;
    logic       advance;

    // Advance the held item when the result register can take it
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    ucfs_splitter u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (config_mode_active),
        .item_step (advance),
        .item_byte (in_byte_reg),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid           = out_valid_reg;
    assign event_kind          = out_res_reg.kind;
    assign text_char           = out_res_reg.ch;
    assign line_length         = out_res_reg.len;
    assign capture_frame_count = out_res_reg.count;

`ifndef ASSERT_OFF
    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held item lost during result stall");

    a_busy_means_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg)
        else $error("input blocked with nothing held");
`endif

endmodule

/* dv/uart_line_and_cobs_frame_splitter_unit_test.sv */
// Self-checking testbench for the UART line and COBS frame splitter.
`timescale 1ns / 1ps

module uart_line_and_cobs_frame_splitter_unit_test;
    import ucfs_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 190;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_REPORTS     = 40;

    // One splitter event, fields in port order
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  ch;
        logic [6:0]  len;
        logic [31:0] count;
    } split_event_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_RESULT,
        ROW_TYPED
    } row_check_t;

    typedef struct packed {
        logic [7:0]   rx;
        row_check_t   chk;
        split_event_t ev;
    } stim_row_t;

    localparam split_event_t NO_EVENT = '{EV_TEXT, 8'h00, 7'd0, 32'd0};

    // Directed rows: text, empty lines, frame open clearing a line, empty frame,
    // a capture with the largest count, and a truncated block
    localparam stim_row_t DIRECTED_ROWS [22] = '{
        '{8'h41,   ROW_TYPED,     '{EV_TEXT, 8'h41, 7'd0, 32'd0}},
        '{CHAR_CR, ROW_TYPED,     '{EV_LINE_END, 8'h00, 7'd1, 32'd0}},
        '{CHAR_LF, ROW_NO_RESULT, NO_EVENT},
        '{8'hFF,   ROW_TYPED,     '{EV_TEXT, 8'hFF, 7'd0, 32'd0}},
        '{8'h00,   ROW_NO_RESULT, NO_EVENT},
        '{8'h00,   ROW_NO_RESULT, NO_EVENT},
        '{CHAR_CR, ROW_NO_RESULT, NO_EVENT},
        '{8'h00,   ROW_NO_RESULT, NO_EVENT},
        '{8'h07,   ROW_NO_RESULT, NO_EVENT},
        '{8'h01,   ROW_NO_RESULT, NO_EVENT},
        '{8'h01,   ROW_NO_RESULT, NO_EVENT},
        '{8'hFF,   ROW_NO_RESULT, NO_EVENT},
        '{8'hFF,   ROW_NO_RESULT, NO_EVENT},
        '{8'hFF,   ROW_NO_RESULT, NO_EVENT},
        '{8'hFF,   ROW_NO_RESULT, NO_EVENT},
        '{8'h00,   ROW_TYPED,     '{EV_CAPTURE, 8'h00, 7'd0, 32'hFFFF_FFFF}},
        '{8'h00,   ROW_NO_RESULT, NO_EVENT},
        '{8'h05,   ROW_NO_RESULT, NO_EVENT},
        '{8'h01,   ROW_NO_RESULT, NO_EVENT},
        '{8'h00,   ROW_NO_RESULT, NO_EVENT},
        '{8'h80,   ROW_PREDICT,   NO_EVENT},
        '{CHAR_LF, ROW_PREDICT,   NO_EVENT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        config_mode_active = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_kind;
    logic [7:0]  text_char;
    logic [6:0]  line_length;
    logic [31:0] capture_frame_count;

    // Predicted splitter state
    logic       mode_cfg = 1'b0;
    logic       in_frame = 1'b0;
    int         frame_len = 0;
    int         line_len = 0;
    int         block_left = 0;
    logic       zero_due = 1'b0;
    int         decoded_n = 0;
    logic [7:0] decoded [6] = '{default: 8'h00};

    split_event_t pending_events[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           sent_count = 0;
    int           burst_left = 0;
    int           hold_reqs = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    logic         rdy_state = 1'b0;
    int           run_left = 0;

    uart_line_and_cobs_frame_splitter_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .config_mode_active  (config_mode_active),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .event_kind          (event_kind),
        .text_char           (text_char),
        .line_length         (line_length),
        .capture_frame_count (capture_frame_count)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic void restart_decoder();
        block_left = 0;
        zero_due   = 1'b0;
        decoded_n  = 0;
    endfunction

    function automatic void push_decoded(input logic [7:0] v);
        if (decoded_n < int'(REQ_DECODED_LEN))
            decoded[decoded_n] = v;
        if (decoded_n < int'(DEC_COUNT_MAX))
            decoded_n++;
    endfunction

    // Advance the predicted state by one byte; return 1 with the event if one is due
    function automatic bit predict_event(input logic [7:0] b, output split_event_t ev);
        bit ok;
        ev = NO_EVENT;
        if (in_frame)
        begin
            if (b == 8'h00)
            begin
                ok = (frame_len > 0) && (block_left == 0) &&
                     (decoded_n == int'(REQ_DECODED_LEN)) &&
                     (decoded[0] == REQ_TYPE_START) &&
                     (decoded[1] == REQ_PROTOCOL_VERSION);
                in_frame  = 1'b0;
                frame_len = 0;
                line_len  = 0;
                if (ok)
                begin
                    ev.kind  = EV_CAPTURE;
                    ev.count = {decoded[5], decoded[4], decoded[3], decoded[2]};
                end
                restart_decoder();
                return ok;
            end
            if (frame_len < FRAME_STORE_BYTES)
            begin
                frame_len++;
                if (block_left == 0)
                begin
                    // code byte: emit the implied zero of the previous block
                    if (zero_due)
                        push_decoded(8'h00);
                    zero_due   = (b != COBS_NO_ZERO_CODE);
                    block_left = int'(b) - 1;
                end
                else
                begin
                    push_decoded(b);
                    block_left--;
                end
            end
            else
            begin
                // drop the frame; what follows is text
                in_frame  = 1'b0;
                frame_len = 0;
                restart_decoder();
            end
            return 1'b0;
        end

        if (b == 8'h00)
        begin
            in_frame  = 1'b1;
            frame_len = 0;
            line_len  = 0;
            restart_decoder();
            return 1'b0;
        end

        if (b == CHAR_CR || b == CHAR_LF)
        begin
            if (line_len == 0)
                return 1'b0;
            ev.kind  = EV_LINE_END;
            ev.len   = (line_len > int'(LINE_LEN_MAX)) ? LINE_LEN_MAX : 7'(line_len);
            line_len = 0;
            return 1'b1;
        end

        if (line_len + 1 < LINE_STORE_BYTES)
        begin
            line_len++;
            ev.kind = EV_TEXT;
            ev.ch   = b;
            return 1'b1;
        end

        line_len = 0;
        if (mode_cfg)
        begin
            ev.kind = EV_TOO_LONG;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one item, hold it until accepted, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input row_check_t chk,
                             input split_event_t typed);
        int           gap;
        bit           has;
        split_event_t ev;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        sent_count++;
        has = predict_event(b, ev);
        if (chk == ROW_TYPED)
            pending_events.push_back(typed);
        else if (chk == ROW_PREDICT && has)
            pending_events.push_back(ev);
    endtask

    task automatic send_data(input logic [7:0] b);
        send_byte(b, ROW_PREDICT, NO_EVENT);
    endtask

    // Write the mode register once the block has gone quiet
    task automatic set_config_mode(input logic v);
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we             <= 1'b1;
        config_mode_active <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_cfg = v;
    endtask

    function automatic logic [7:0] draw_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_CR || c == CHAR_LF);
        return c;
    endfunction

    task automatic send_line(input int n);
        for (int i = 0; i < n; i++)
            send_data(draw_text_char());
        case ($urandom_range(0, 3))
            0: send_data(CHAR_CR);
            1: send_data(CHAR_LF);
            2:
            begin
                send_data(CHAR_CR);
                send_data(CHAR_LF);
            end
            default: ;
        endcase
    endtask

    // Mostly well-formed lines and capture frames, some overflowing frames and noise
    task automatic send_random_unit();
        int         pick;
        int         n;
        int         plen;
        int         elen;
        int         code_at;
        logic [7:0] pay [12];
        logic [7:0] enc [14];
        pick = $urandom_range(0, 9);
        if (pick <= 3)
        begin
            n = ($urandom_range(0, 11) == 0) ? int'($urandom_range(100, 135))
                                             : int'($urandom_range(1, 24));
            send_line(n);
        end
        else if (pick <= 6)
        begin
            plen = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 10)) : 6;
            for (int i = 0; i < 12; i++)
                pay[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 5) != 0)
            begin
                pay[0] = REQ_TYPE_START;
                pay[1] = REQ_PROTOCOL_VERSION;
            end
            // COBS encode: each code byte counts its block plus one
            code_at = 0;
            elen    = 1;
            for (int i = 0; i < plen; i++)
            begin
                if (pay[i] == 8'h00)
                begin
                    enc[code_at] = 8'(elen - code_at);
                    code_at      = elen;
                    elen++;
                end
                else
                begin
                    enc[elen] = pay[i];
                    elen++;
                end
            end
            enc[code_at] = 8'(elen - code_at);
            if ($urandom_range(0, 7) == 0 && elen > 1)
                elen -= int'($urandom_range(1, elen - 1));
            if (in_frame)
                send_data(8'h00);
            send_data(8'h00);
            for (int i = 0; i < elen; i++)
                send_data(enc[i]);
            send_data(8'h00);
        end
        else if (pick == 7)
        begin
            if (in_frame)
                send_data(8'h00);
            send_data(8'h00);
            n = $urandom_range(28, 40);
            for (int i = 0; i < n; i++)
                send_data(8'($urandom_range(1, 255)));
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_data(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: stall pattern, long hold-offs on request, and the check
    always @(posedge clk)
    begin : result_side
        split_event_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                    report_mismatch("unexpected result, kind", 32'(event_kind), 32'd0);
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                        report_mismatch("event_kind", 32'(event_kind), 32'(want.kind));
                    if (text_char !== want.ch)
                        report_mismatch("text_char", 32'(text_char), 32'(want.ch));
                    if (line_length !== want.len)
                        report_mismatch("line_length", 32'(line_length), 32'(want.len));
                    if (capture_frame_count !== want.count)
                        report_mismatch("capture_frame_count", capture_frame_count,
                                        want.count);
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    rdy_state = !rdy_state;
                    run_left  = rdy_state ? int'($urandom_range(1, 40))
                                          : int'($urandom_range(1, 6));
                end
                run_left--;
                out_ready <= rdy_state;
            end
        end
    end

    // Reset, directed rows, then random phases across both mode settings
    initial
    begin
        int start_items;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config_mode(1'b0);

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].ev);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_config_mode(phase[0]);
            if (phase == 2 || phase == 5)
                hold_reqs++;
            start_items = sent_count;
            // lines around the store limit: 127 characters, overflow and beyond
            send_line($urandom_range(126, 135));
            while (sent_count - start_items < PHASE_ITEMS)
                send_random_unit();
        end

        // Drain, then watch for stray results
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
